@@ design/mnt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mnt_pkg
// Shared types and constants of the mesh neighbor table.
// ----------------------------------------------------------------------------
package mnt_pkg;

  localparam logic [7:0] BCAST_ID = 8'hFF;
  localparam logic signed [7:0] RSSI_FLOOR = -8'sd127;

  localparam logic [1:0] CFG_OWN_ID  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAXHOPS = 2'd2;

  typedef enum logic [2:0] {
    FN_UPDATE = 3'd0,
    FN_AGE    = 3'd1,
    FN_NHOP   = 3'd2,
    FN_RELAY  = 3'd3,
    FN_QUERY  = 3'd4,
    FN_FORGET = 3'd5,
    FN_CLEAR  = 3'd6,
    FN_NOP    = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WAIT,
    ST_POINT,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/mesh_neighbor_table_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_neighbor_table_unit
// Neighbor table with update, age out, next hop, relay, query, forget, clear.
// ----------------------------------------------------------------------------
// Start an item with start while busy is low. Single-entry operations
// (update, relay, query, forget, nop, and next hop to self or broadcast)
// step through the look, wait and point states to the done state; age out,
// next hop and clear walk every slot through one memory read port and one
// shared age / rank compare unit in the scan states. The out_valid strobe
// is registered from the done state; busy stays high until the strobe cycle.
// Each result is shown for one cycle on out_valid and cannot be held off.
// Valid bits are flip-flops cleared by reset; entry payload is in a memory.
// ----------------------------------------------------------------------------
module mesh_neighbor_table_unit #(
  parameter int NODE_SLOTS = 256
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [2:0]          in_func,
  input  wire  [7:0]          in_node_id,
  input  wire  signed [7:0]   in_rssi,
  input  wire  [7:0]          in_hop_count,
  input  wire                 in_relay_flag,
  input  wire  [31:0]         in_now_ms,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_wdata,
  output logic                out_valid,
  output logic                out_hit,
  output logic                out_new_neighbor,
  output logic [7:0]          out_next_hop,
  output logic [7:0]          out_hops_out,
  output logic signed [7:0]   out_rssi_out,
  output logic [31:0]         out_packets_out,
  output logic [8:0]          out_removed_count
);
  import mnt_pkg::*;

  localparam int AW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW = $clog2(NODE_SLOTS + 1);

  // configuration
  logic [7:0]  own_id_r;
  logic [31:0] timeout_r;
  logic [7:0]  max_hops_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= 8'd1;
      timeout_r  <= 32'd60000;
      max_hops_r <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:  own_id_r   <= cfg_wdata[7:0];
        CFG_TIMEOUT: timeout_r  <= cfg_wdata;
        CFG_MAXHOPS: max_hops_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // latched item
  func_t       func_r;
  logic [7:0]  id_r;
  logic [7:0]  rssi_r;
  logic [7:0]  hops_r;
  logic        rflag_r;
  logic [31:0] now_r;

  state_t state_r, state_nxt;
  logic [AW-1:0] idx_r;   // slot being addressed
  logic [AW-1:0] pidx_r;  // slot whose data is on rd_*

  // entry memory: {packets, last_seen, hops, rssi}
  logic [7:0]  mem_rssi [NODE_SLOTS];
  logic [7:0]  mem_hops [NODE_SLOTS];
  logic [31:0] mem_seen [NODE_SLOTS];
  logic [31:0] mem_pk   [NODE_SLOTS];
  logic [7:0]  rd_rssi, rd_hops;
  logic [31:0] rd_seen, rd_pk;
  logic        valid_r [NODE_SLOTS];

  logic        mem_we;
  logic [31:0] wr_pk;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_rssi[idx_r] <= rssi_r;
      mem_hops[idx_r] <= hops_r;
      mem_seen[idx_r] <= now_r;
      mem_pk[idx_r]   <= wr_pk;
    end
    rd_rssi <= mem_rssi[idx_r];
    rd_hops <= mem_hops[idx_r];
    rd_seen <= mem_seen[idx_r];
    rd_pk   <= mem_pk[idx_r];
  end

  // id qualifiers
  logic id_in_range, id_special, cur_valid;
  assign id_in_range = ({24'd0, id_r} < 32'(NODE_SLOTS));
  assign id_special  = (id_r == own_id_r) || (id_r == BCAST_ID);
  assign cur_valid   = id_in_range && valid_r[idx_r];

  // shared compare unit, working on the slot read last cycle
  logic        scan_valid;
  logic [31:0] age;
  logic        stale;
  logic        better;
  logic [7:0]  best_h_r;
  logic signed [7:0] best_r_r;
  logic [7:0]  best_id_r;
  logic [CW-1:0] removed_r;

  assign scan_valid = valid_r[pidx_r];
  assign age   = now_r - rd_seen;
  assign stale = age > timeout_r;
  assign better = (rd_hops < max_hops_r) &&
                  ((rd_hops < best_h_r) ||
                   ((rd_hops == best_h_r) && ($signed(rd_rssi) > best_r_r)));

  assign wr_pk = cur_valid ? (rd_pk + 32'd1) : 32'd1;

  logic last_idx;
  assign last_idx = (idx_r == AW'(NODE_SLOTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (start) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (func_r == FN_AGE || func_r == FN_CLEAR ||
            (func_r == FN_NHOP && !id_special))
          state_nxt = ST_SCAN;
        else
          state_nxt = ST_WAIT;
      end
      ST_WAIT:      state_nxt = ST_POINT;
      ST_POINT:     state_nxt = ST_DONE;
      ST_SCAN:      if (last_idx) state_nxt = ST_SCAN_LAST;
      ST_SCAN_LAST: state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy   = (state_r != ST_IDLE);
    mem_we = (state_r == ST_POINT) && (func_r == FN_UPDATE) &&
             !id_special && id_in_range;
  end

  logic res_hit, res_new;
  logic [7:0] res_hops, res_rssi;
  logic [31:0] res_pk;
  logic res_hit_nxt, res_new_nxt;
  logic [7:0] res_hops_nxt, res_rssi_nxt;
  logic [31:0] res_pk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NODE_SLOTS; i++) valid_r[i] <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_DONE);
      if (state_r == ST_POINT) begin
        if (mem_we) valid_r[idx_r] <= 1'b1;
        if (func_r == FN_FORGET && cur_valid) valid_r[idx_r] <= 1'b0;
      end
      if ((state_r == ST_SCAN && idx_r != AW'(0) || state_r == ST_SCAN_LAST) &&
          scan_valid &&
          (func_r == FN_CLEAR || (func_r == FN_AGE && stale)))
        valid_r[pidx_r] <= 1'b0;
    end
  end

  // single-entry result fields; defaults outside the point cycle
  always_comb begin
    res_hit_nxt  = 1'b0;
    res_new_nxt  = 1'b0;
    res_hops_nxt = BCAST_ID;
    res_rssi_nxt = 8'd0;
    res_pk_nxt   = 32'd0;
    if (state_r == ST_POINT) begin
      case (func_r)
        FN_UPDATE: begin
          res_hit_nxt = !id_special && id_in_range;
          res_new_nxt = !id_special && id_in_range && !cur_valid;
        end
        FN_RELAY:  res_hit_nxt = !id_special && !rflag_r && cur_valid;
        FN_QUERY: begin
          if (id_r == own_id_r) begin
            res_hit_nxt  = 1'b1;
            res_hops_nxt = 8'd0;
          end else if (cur_valid) begin
            res_hit_nxt  = 1'b1;
            res_hops_nxt = rd_hops;
            res_rssi_nxt = rd_rssi;
            res_pk_nxt   = rd_pk;
          end
        end
        FN_FORGET: res_hit_nxt = cur_valid;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
    if (state_r == ST_IDLE && start) begin
      func_r  <= func_t'(in_func);
      id_r    <= in_node_id;
      rssi_r  <= in_rssi;
      hops_r  <= in_hop_count;
      rflag_r <= in_relay_flag;
      now_r   <= in_now_ms;
      idx_r   <= in_node_id[AW-1:0];
      best_h_r  <= BCAST_ID;
      best_r_r  <= RSSI_FLOOR;
      best_id_r <= BCAST_ID;
      removed_r <= '0;
    end
    if (state_r == ST_LOOK && state_nxt == ST_SCAN) idx_r <= '0;
    if (state_r == ST_SCAN && !last_idx) idx_r <= idx_r + AW'(1);
    // fold in slot pidx_r
    if ((state_r == ST_SCAN && idx_r != AW'(0)) || state_r == ST_SCAN_LAST) begin
      if (scan_valid) begin
        if (func_r == FN_CLEAR || (func_r == FN_AGE && stale))
          removed_r <= removed_r + CW'(1);
        if (func_r == FN_NHOP && better) begin
          best_h_r  <= rd_hops;
          best_r_r  <= $signed(rd_rssi);
          best_id_r <= 8'(pidx_r);
        end
      end
    end
    if (state_r == ST_POINT || state_r == ST_SCAN_LAST ||
        (state_r == ST_LOOK && state_nxt != ST_WAIT)) begin
      res_hit  <= res_hit_nxt;
      res_new  <= res_new_nxt;
      res_hops <= res_hops_nxt;
      res_rssi <= res_rssi_nxt;
      res_pk   <= res_pk_nxt;
    end
  end

  // result drive
  always_comb begin
    out_hit           = res_hit;
    out_new_neighbor  = res_new;
    out_hops_out      = res_hops;
    out_rssi_out      = res_rssi;
    out_packets_out   = res_pk;
    out_next_hop      = (func_r == FN_NHOP && !id_special) ? best_id_r : BCAST_ID;
    out_removed_count = (func_r == FN_AGE || func_r == FN_CLEAR) ?
                        9'(removed_r) : 9'd0;
  end

endmodule

`default_nettype wire
